[rtl/swre_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package swre_pkg;
    localparam int WINDOW_DEF = 12;
    localparam int NLET = 20;
    localparam logic [4:0] NOT_LETTER = 5'd20;

    // Maps a byte to its letter index, or NOT_LETTER.
    function automatic logic [4:0] letter_of(input logic [7:0] b);
        logic [7:0] c;
        logic [4:0] r;
        begin
            c = (b >= 8'h61 && b <= 8'h7a) ? b - 8'd32 : b;
            case (c)
                8'h41: r = 5'd0;
                8'h43: r = 5'd1;
                8'h44: r = 5'd2;
                8'h45: r = 5'd3;
                8'h46: r = 5'd4;
                8'h47: r = 5'd5;
                8'h48: r = 5'd6;
                8'h49: r = 5'd7;
                8'h4b: r = 5'd8;
                8'h4c: r = 5'd9;
                8'h4d: r = 5'd10;
                8'h4e: r = 5'd11;
                8'h50: r = 5'd12;
                8'h51: r = 5'd13;
                8'h52: r = 5'd14;
                8'h53: r = 5'd15;
                8'h54: r = 5'd16;
                8'h56: r = 5'd17;
                8'h57: r = 5'd18;
                8'h59: r = 5'd19;
                default: r = NOT_LETTER;
            endcase
            letter_of = r;
        end
    endfunction

    // Q.32 log2 by repeated squaring; evaluated on constants only to build tables.
    function automatic logic [39:0] log2_q32(input int n);
        int k;
        logic [63:0] x;
        logic [31:0] fr;
        begin
            k = 0;
            fr = '0;
            if (n == 0)
                return '0;
            while (k < 31 && (n >> (k + 1)) != 0)
                k++;
            x = (64'(n) << 31) >> k;
            for (int i = 0; i < 32; i++)
            begin
                x = (x * x) >> 31;
                fr = fr << 1;
                if (x >= 64'h1_0000_0000)
                begin
                    x = x >> 1;
                    fr[0] = 1'b1;
                end
            end
            log2_q32 = {8'(k), fr};
        end
    endfunction

    typedef struct packed {
        logic       clear;
        logic [4:0] add_idx;
        logic [4:0] sub_idx;
        logic       full;
    } swre_cmd_t;
endpackage
`default_nettype wire

[rtl/swre_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module swre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 12
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/swre_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module swre_front import swre_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] residue,
    input  wire logic       new_sequence,
    output logic            cmd_valid,
    input  wire logic       cmd_ready,
    output swre_cmd_t       cmd
);
    localparam int PW = $clog2(WINDOW);
    localparam int FW = $clog2(WINDOW + 1);
    typedef enum logic [1:0] {S_IDLE, S_READ, S_OUT} state_t;

    state_t state_reg;
    logic [PW-1:0] ptr_reg;
    logic [FW-1:0] fill_reg;
    logic [7:0] byte_reg;
    logic clr_reg;
    logic [PW-1:0] p;
    logic [FW-1:0] f;
    logic [7:0] rdata;
    logic full;

    assign p = new_sequence ? '0 : ptr_reg;
    assign f = clr_reg ? '0 : fill_reg;
    assign full = (f == FW'(WINDOW));
    assign in_ready = (state_reg == S_IDLE);

    swre_ram #(.WIDTH(8), .DEPTH(WINDOW)) u_ram (
        .clk(clk), .we(in_valid && in_ready), .waddr(p), .wdata(residue),
        .raddr(p), .rdata(rdata));

    assign cmd_valid = (state_reg == S_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ptr_reg <= '0;
            fill_reg <= '0;
            clr_reg <= 1'b0;
            byte_reg <= '0;
            cmd <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        // The RAM read of the outgoing slot happens this edge.
                        byte_reg <= residue;
                        clr_reg <= new_sequence;
                        ptr_reg <= (p == PW'(WINDOW - 1)) ? '0 : p + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    cmd.clear <= clr_reg;
                    cmd.add_idx <= letter_of(byte_reg);
                    cmd.sub_idx <= full ? letter_of(rdata) : NOT_LETTER;
                    cmd.full <= full ? 1'b1 : (f + 1'b1 == FW'(WINDOW));
                    if (!full)
                        fill_reg <= f + 1'b1;
                    else
                        fill_reg <= f;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (cmd_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/swre_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module swre_back import swre_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  wire swre_cmd_t   cmd,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [18:0]      entropy_bits,
    output logic [3:0]       counted_residues,
    output logic             window_full
);
    localparam int CW = $clog2(WINDOW + 1);
    localparam int SW = 40 + CW;
    typedef enum logic [2:0] {S_IDLE, S_ACC, S_DIV, S_FIN, S_OUT} state_t;

    state_t state_reg;
    logic [CW-1:0] cnt_reg [NLET];
    logic [CW-1:0] tot_reg;
    logic [4:0] idx_reg;
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] rem_reg;
    logic [39:0] q_reg;
    logic [5:0] bit_reg;
    logic [39:0] lt_reg;
    logic full_reg;
    logic fullwin_reg;
    logic [18:0] ent_reg;

    // Per-count terms, evaluated on constants only to fill the tables below.
    function automatic logic [SW-1:0] plain_term(input int n);
        plain_term = SW'(n) * SW'(log2_q32(n));
    endfunction
    function automatic logic [39:0] fterm(input int c);
        logic [SW-1:0] t;
        t = SW'(c) * SW'(log2_q32(WINDOW) - log2_q32(c));
        fterm = 40'(t / SW'(WINDOW));
    endfunction

    logic [39:0]   lg_tab [WINDOW+1];
    logic [SW-1:0] term_tab [WINDOW+1];
    logic [39:0]   fterm_tab [WINDOW+1];

    for (genvar g = 0; g <= WINDOW; g++)
    begin : g_tab
        assign lg_tab[g] = log2_q32(g);
        assign term_tab[g] = plain_term(g);
        assign fterm_tab[g] = fterm(g);
    end

    logic [CW-1:0] c_cur;
    logic [SW-1:0] prod;
    logic [SW:0] trial;
    logic [39:0] diff;
    logic [40:0] rnd;

    assign c_cur = cnt_reg[idx_reg];
    assign prod = fullwin_reg ? SW'(fterm_tab[c_cur]) : term_tab[c_cur];
    assign trial = {rem_reg, sum_reg[SW-1]} - {1'b0, SW'(tot_reg)};
    assign diff = (q_reg > lt_reg) ? 40'd0 : lt_reg - q_reg;
    assign rnd = {1'b0, fullwin_reg ? sum_reg[39:0] : diff} + 41'h8000;

    assign cmd_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign entropy_bits = ent_reg;
    assign window_full = full_reg;
    assign counted_residues = 4'(tot_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < NLET; i++)
                cnt_reg[i] <= '0;
            tot_reg <= '0;
            full_reg <= 1'b0;
            fullwin_reg <= 1'b0;
            idx_reg <= '0;
            sum_reg <= '0;
            rem_reg <= '0;
            q_reg <= '0;
            bit_reg <= '0;
            lt_reg <= '0;
            ent_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        logic [CW-1:0] t;
                        t = cmd.clear ? '0 : tot_reg;
                        for (int i = 0; i < NLET; i++)
                        begin
                            logic [CW-1:0] c;
                            c = cmd.clear ? '0 : cnt_reg[i];
                            if (cmd.sub_idx == 5'(i) && c != 0)
                            begin
                                c = c - 1'b1;
                                t = t - 1'b1;
                            end
                            if (cmd.add_idx == 5'(i))
                            begin
                                c = c + 1'b1;
                                t = t + 1'b1;
                            end
                            cnt_reg[i] <= c;
                        end
                        tot_reg <= t;
                        full_reg <= cmd.full;
                        fullwin_reg <= (t == CW'(WINDOW));
                        idx_reg <= '0;
                        sum_reg <= '0;
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    lt_reg <= lg_tab[tot_reg];
                    if (c_cur != 0)
                        sum_reg <= sum_reg + prod;
                    if (idx_reg == 5'(NLET - 1))
                    begin
                        rem_reg <= '0;
                        q_reg <= '0;
                        bit_reg <= 6'(SW - 1);
                        state_reg <= (fullwin_reg || tot_reg == 0) ? S_FIN : S_DIV;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_DIV:
                begin
                    // Restoring division, one quotient bit a cycle.
                    if (!trial[SW])
                        rem_reg <= trial[SW-1:0];
                    else
                        rem_reg <= {rem_reg[SW-2:0], sum_reg[SW-1]};
                    sum_reg <= {sum_reg[SW-2:0], 1'b0};
                    q_reg <= {q_reg[38:0], ~trial[SW]};
                    if (bit_reg == 0)
                        state_reg <= S_FIN;
                    else
                        bit_reg <= bit_reg - 1'b1;
                end
                S_FIN:
                begin
                    if (tot_reg == 0)
                        ent_reg <= '0;
                    else if (rnd[40:16] > 25'h7FFFF)
                        ent_reg <= 19'h7FFFF;
                    else
                        ent_reg <= rnd[34:16];
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/sliding_window_residue_entropy.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sliding-window residue entropy: each input beat carries one sequence byte and a
// new-sequence flag; one output beat follows with the Shannon entropy (Q.16) of
// the counted amino-acid letters in the last WINDOW bytes. A front stage updates
// the byte ring and classifies the incoming and outgoing bytes; the back stage
// updates counts, sums 20 letter terms one per cycle and, for a partial window
// holding letters, runs a bit-serial divider. The front stage can take the next
// byte while the back stage still works on the previous one.
module sliding_window_residue_entropy import swre_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // residue[7:0]
    input  wire logic        s_tuser,   // new_sequence
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // entropy_bits[18:0], counted_residues[22:19], window_full[23]
);
    logic cmd_valid, cmd_ready;
    swre_cmd_t cmd;
    logic [18:0] ent;
    logic [3:0] cnt;
    logic wf;

    swre_front #(.WINDOW(WINDOW)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .residue(s_tdata), .new_sequence(s_tuser),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd));

    swre_back #(.WINDOW(WINDOW)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
        .cmd(cmd), .out_valid(m_tvalid), .out_ready(m_tready),
        .entropy_bits(ent), .counted_residues(cnt), .window_full(wf));

    assign m_tdata = {wf, cnt, ent};

    a_no_zero_entropy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && cnt == 4'd0 && WINDOW < 16 |-> ent == 19'd0)
        else $error("entropy nonzero with no letters");
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
        else $error("command changed while stalled");
endmodule
`default_nettype wire

[verif/sliding_window_residue_entropy_checker.sv]
`timescale 1ns / 1ps
module sliding_window_residue_entropy_checker import swre_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int          fail_count,
    output int          pending
);
    typedef struct packed {
        logic        full;
        logic [3:0]  counted;
        logic [18:0] entropy;
    } window_stat_t;

    logic [7:0]  ring [WINDOW];
    int          counts [20];
    int          held;
    int          wr_slot;
    window_stat_t stat_queue [$];

    function automatic int residue_class(logic [7:0] b);
        logic [7:0] u;
        string      alphabet;
        u = (b >= "a" && b <= "z") ? b - 8'd32 : b;
        alphabet = "ACDEFGHIKLMNPQRSTVWY";
        for (int i = 0; i < 20; i++)
            if (alphabet[i] == u)
                return i;
        return 20;
    endfunction

    function automatic logic [63:0] lg2(int n);
        int          k;
        logic [63:0] x;
        logic [31:0] fr;
        k = 0;
        fr = '0;
        if (n == 0)
            return 0;
        while (k < 31 && (n >> (k + 1)) != 0)
            k++;
        x = (64'(n) << 31) >> k;
        for (int i = 0; i < 32; i++)
        begin
            x = (x * x) >> 31;
            fr = fr << 1;
            if (x >= 64'h1_0000_0000)
            begin
                x = x >> 1;
                fr[0] = 1'b1;
            end
        end
        return {32'(k), fr};
    endfunction

    function automatic logic [18:0] window_entropy(int total);
        logic [63:0] e, s, lt, q;
        e = 0;
        s = 0;
        if (total == 0)
            return 0;
        if (total == WINDOW)
        begin
            lt = lg2(WINDOW);
            for (int i = 0; i < 20; i++)
                if (counts[i] != 0)
                    e += (64'(counts[i]) * (lt - lg2(counts[i]))) / 64'(WINDOW);
        end
        else
        begin
            lt = lg2(total);
            for (int i = 0; i < 20; i++)
                if (counts[i] != 0)
                    s += 64'(counts[i]) * lg2(counts[i]);
            q = s / 64'(total);
            e = (q > lt) ? 0 : lt - q;
        end
        e = (e + 64'h8000) >> 16;
        return (e > 64'h7FFFF) ? 19'h7FFFF : e[18:0];
    endfunction

    task automatic absorb_residue(logic [7:0] b, logic fresh);
        int           c;
        int           total;
        window_stat_t st;
        if (fresh)
        begin
            foreach (counts[i])
                counts[i] = 0;
            held = 0;
            wr_slot = 0;
        end
        if (held >= WINDOW)
        begin
            c = residue_class(ring[wr_slot]);
            if (c < 20 && counts[c] != 0)
                counts[c]--;
        end
        else
            held++;
        ring[wr_slot] = b;
        c = residue_class(b);
        if (c < 20)
            counts[c]++;
        wr_slot = (wr_slot + 1) % WINDOW;
        total = 0;
        foreach (counts[i])
            total += counts[i];
        st.entropy = window_entropy(total);
        st.counted = 4'(total);
        st.full = held >= WINDOW;
        stat_queue.push_back(st);
    endtask

    assign pending = stat_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        window_stat_t got, want;
        if (!rst_n)
        begin
            foreach (counts[i])
                counts[i] = 0;
            held = 0;
            wr_slot = 0;
            fail_count = 0;
            stat_queue.delete();
        end
        else
        begin
            // Take the result before the input so a same-edge beat cannot be matched.
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (stat_queue.size() == 0)
                begin
                    $error("unexpected result beat %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = stat_queue.pop_front();
                    if (got.entropy !== want.entropy)
                    begin
                        $error("entropy_bits expected %0d got %0d", want.entropy, got.entropy);
                        fail_count++;
                    end
                    if (got.counted !== want.counted)
                    begin
                        $error("counted_residues expected %0d got %0d",
                               want.counted, got.counted);
                        fail_count++;
                    end
                    if (got.full !== want.full)
                    begin
                        $error("window_full expected %0d got %0d", want.full, got.full);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                absorb_residue(s_tdata, s_tuser);
        end
    end
endmodule

[verif/sliding_window_residue_entropy_tb.sv]
`timescale 1ns / 1ps
module sliding_window_residue_entropy_tb;
    import swre_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    int          fail_count;
    int          pending;
    bit          hold_off;

    sliding_window_residue_entropy i_dut (.*);

    sliding_window_residue_entropy_checker i_checker (.*);

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Output stall pattern, with one long hold-off while the input keeps offering.
    initial
    begin
        int mode;
        m_tready = 1'b0;
        hold_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                m_tready <= 1'b0;
            else
            begin
                mode = $urandom_range(0, 99);
                m_tready <= (mode < 40) ? 1'b1 :
                            (mode < 75) ? 1'($urandom_range(0, 1)) : 1'b0;
            end
        end
    end

    initial
    begin
        repeat (400) @(posedge clk);
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
    end

    task automatic send_residue(logic [7:0] b, logic fresh);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= fresh;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic pause(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic logic [7:0] random_residue(int mode);
        string alphabet;
        alphabet = "ACDEFGHIKLMNPQRSTVWY";
        if (mode < 70)
            return alphabet[$urandom_range(0, 19)];
        if (mode < 85)
            return alphabet[$urandom_range(0, 19)] + 8'd32;
        if (mode < 92)
            return alphabet[$urandom_range(0, 2)];
        return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        int wait_cycles;
        int burst;
        int flavor;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        rst_n    = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty window, non-letters, mixed case, a full window of one letter,
        // high bytes and a restart mid-sequence.
        send_residue(8'h00, 1'b1);
        send_residue(8'hFF, 1'b0);
        send_residue("a", 1'b0);
        send_residue("Y", 1'b0);
        for (int i = 0; i < 12; i++)
            send_residue("W", 1'b0);
        send_residue(8'h80, 1'b0);
        send_residue("B", 1'b0);
        send_residue("y", 1'b1);
        send_residue("A", 1'b0);
        send_residue(8'h7F, 1'b0);
        send_residue("Z", 1'b0);
        send_residue("c", 1'b0);

        for (int n = 0; n < 1650; n += burst)
        begin
            burst = $urandom_range(1, 40);
            flavor = $urandom_range(0, 99);
            for (int j = 0; j < burst; j++)
                send_residue(random_residue(flavor),
                             ($urandom_range(0, 199) == 0) || (j == 0 && flavor < 10));
            if ($urandom_range(0, 2) != 0)
                pause($urandom_range(1, 80));
        end
        s_tvalid <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
